[design/fssd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fssd_pkg: shared types and constants of the frequency seven-segment driver
// Digit layout, conversion widths, the segment table and the sequencer states.
// ----------------------------------------------------------------------------
package fssd_pkg;

    localparam int HZ_W           = 37;            // input frequency width
    localparam int HZ_DIGITS      = 12;            // decimal digits of the input
    localparam int BCD_W          = 4 * HZ_DIGITS;
    localparam int TENS_W         = BCD_W - 4;     // digits of frequency / 10
    localparam int CNT_W          = 6;             // conversion step counter
    localparam int POS_W          = 4;
    localparam int VAL_W          = 4;
    localparam int SEG_W          = 7;
    localparam int CFG_W          = 3;
    localparam int MAX_MHZ_DIGITS = 5;
    localparam int FIXED_DIGITS   = 5;             // 10 Hz up to 100 kHz
    localparam int DP_POS         = 4;             // 100 kHz digit
    localparam int SMALL_DIGITS   = 2;             // 10 Hz and 100 Hz

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HZ_W - 1);
    localparam logic [POS_W-1:0] FIRST_MHZ_POS = POS_W'(FIXED_DIGITS);

    localparam int IN_TDATA_W  = ((HZ_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = POS_W + VAL_W + SEG_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_CHECK,
        ST_EMIT
    } state_t;

    // segments a..g in bits 0..6
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [VAL_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[design/frequency_seven_segment_driver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// frequency_seven_segment_driver: frequency to seven-segment digit stream
// Turns a frequency in hertz into display digits with segment patterns.
//
// Input stream: one word per frequency, frequency_hz in s_axis_tdata[36:0].
// Output stream: one word per display digit, 10 Hz digit first, tlast on the
// final digit. There are five fixed digits (10 Hz up to 100 kHz) and one to
// five MHz digits, taken from the mhz_digit_count register or, when it is 0,
// from the size of the frequency. Leading zero MHz digits come out blanked.
// If frequency / 10 equals that of the last frequency shown, no digit is sent.
// Timing: a shift-and-add-3 unit converts the frequency to decimal, one bit
// per cycle, then a check state compares and picks the digit count. The
// digits leave one per cycle while the receiver takes them. s_axis_tready
// is low while an item is converted, checked and sent, so no new word is
// taken before the item ahead of it is done. A stalled receiver holds the
// current digit and the sequencer.
// Configuration writes are always taken (cfg_ready is high).
// Reset clears the digit count register to automatic and the stored
// frequency / 10 to zero, so a frequency below 10 Hz after reset sends nothing.
// ----------------------------------------------------------------------------
module frequency_seven_segment_driver (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // frequency_hz [36:0], zero padding above
    input  wire logic [fssd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // digit_position [3:0], digit_value [7:4], segments [14:8], zero at [15]
    output logic [fssd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // blanked [0], decimal_point [1], small_digit [2]
    output logic [fssd_pkg::OUT_TUSER_W-1:0]         m_axis_tuser,
    output logic                                     m_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [fssd_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready
);

    fssd_pkg::state_t                      state_reg, state_next;
    logic [fssd_pkg::HZ_W-1:0]             bin_reg;
    logic [fssd_pkg::BCD_W-1:0]            digits_reg, digits_next;
    logic [fssd_pkg::CNT_W-1:0]            step_reg;
    logic [fssd_pkg::POS_W-1:0]            pos_reg;
    logic [fssd_pkg::POS_W-1:0]            last_pos_reg, last_pos_next;
    logic [fssd_pkg::TENS_W-1:0]           last_tens_reg;
    logic [fssd_pkg::CFG_W-1:0]            mhz_count_reg;

    logic [fssd_pkg::BCD_W-1:0]            adj_bcd;
    logic [fssd_pkg::TENS_W-1:0]           tens_bcd;
    logic                                  tens_same;
    logic [fssd_pkg::POS_W-1:0]            auto_count, mhz_count;
    logic [fssd_pkg::VAL_W-1:0]            cur_digit;
    logic                                  upper_zero;
    logic                                  blank;
    logic                                  in_acc, out_acc, out_done;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign out_done = out_acc && (pos_reg == last_pos_reg);
    assign cfg_ready = 1'b1;

    // add 3 to every digit at 5 or more, ahead of the shift
    always_comb
    begin
        for (int i = 0; i < fssd_pkg::HZ_DIGITS; i++)
        begin
            if (digits_reg[4*i +: 4] >= 4'd5)
                adj_bcd[4*i +: 4] = digits_reg[4*i +: 4] + 4'd3;
            else
                adj_bcd[4*i +: 4] = digits_reg[4*i +: 4];
        end
    end

    // hz units digit dropped: these are the digits of frequency / 10
    assign tens_bcd  = digits_reg[fssd_pkg::BCD_W-1:4];
    assign tens_same = (tens_bcd == last_tens_reg);

    // thresholds read off the decimal digits of the frequency
    always_comb
    begin
        priority if (digits_reg[47:40] != 8'd0)
            auto_count = 4'd5;
        else if (digits_reg[39:36] != 4'd0)
            auto_count = 4'd4;
        else if (digits_reg[35:32] != 4'd0)
            auto_count = 4'd3;
        else if (digits_reg[31:28] != 4'd0)
            auto_count = 4'd2;
        else
            auto_count = 4'd1;
    end

    always_comb
    begin
        if (mhz_count_reg == '0)
            mhz_count = auto_count;
        else
            mhz_count = fssd_pkg::POS_W'(mhz_count_reg);
        if (mhz_count > fssd_pkg::POS_W'(fssd_pkg::MAX_MHZ_DIGITS))
            mhz_count = fssd_pkg::POS_W'(fssd_pkg::MAX_MHZ_DIGITS);
        last_pos_next = fssd_pkg::POS_W'(fssd_pkg::FIXED_DIGITS - 1) + mhz_count;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fssd_pkg::ST_IDLE:
                if (in_acc)
                    state_next = fssd_pkg::ST_CONVERT;
            fssd_pkg::ST_CONVERT:
                if (step_reg == fssd_pkg::LAST_STEP)
                    state_next = fssd_pkg::ST_CHECK;
            fssd_pkg::ST_CHECK:
                if (tens_same)
                    state_next = fssd_pkg::ST_IDLE;
                else
                    state_next = fssd_pkg::ST_EMIT;
            fssd_pkg::ST_EMIT:
                if (out_done)
                    state_next = fssd_pkg::ST_IDLE;
            default:
                state_next = fssd_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            fssd_pkg::ST_IDLE:    s_axis_tready = 1'b1;
            fssd_pkg::ST_CONVERT: ;
            fssd_pkg::ST_CHECK:   ;
            fssd_pkg::ST_EMIT:    m_axis_tvalid = 1'b1;
            default:              ;
        endcase
    end

    always_comb
    begin
        digits_next = digits_reg;
        unique case (state_reg)
            fssd_pkg::ST_IDLE:
                digits_next = '0;
            fssd_pkg::ST_CONVERT:
                digits_next = {adj_bcd[fssd_pkg::BCD_W-2:0], bin_reg[fssd_pkg::HZ_W-1]};
            fssd_pkg::ST_CHECK:
                digits_next = {4'd0, tens_bcd};
            fssd_pkg::ST_EMIT:
                if (out_acc)
                    digits_next = {4'd0, digits_reg[fssd_pkg::BCD_W-1:4]};
            default:
                digits_next = digits_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fssd_pkg::ST_IDLE;
            step_reg      <= '0;
            pos_reg       <= '0;
            last_pos_reg  <= '0;
            last_tens_reg <= '0;
            mhz_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                mhz_count_reg <= cfg_data;
            if (in_acc)
                step_reg <= '0;
            else if (state_reg == fssd_pkg::ST_CONVERT)
                step_reg <= step_reg + 1'b1;
            if (state_reg == fssd_pkg::ST_CHECK)
            begin
                pos_reg      <= '0;
                last_pos_reg <= last_pos_next;
                if (!tens_same)
                    last_tens_reg <= tens_bcd;
            end
            else if (out_acc)
                pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        if (in_acc)
            bin_reg <= s_axis_tdata[fssd_pkg::HZ_W-1:0];
        else if (state_reg == fssd_pkg::ST_CONVERT)
            bin_reg <= {bin_reg[fssd_pkg::HZ_W-2:0], 1'b0};
    end

    // output word straight from the held registers
    assign cur_digit  = digits_reg[3:0];
    assign upper_zero = (digits_reg[fssd_pkg::BCD_W-1:4] == '0);
    assign blank      = (pos_reg >= fssd_pkg::FIRST_MHZ_POS) && (cur_digit == 4'd0) && upper_zero;

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[3:0] = pos_reg;
        m_axis_tdata[7:4] = blank ? 4'd0 : cur_digit;
        m_axis_tdata[14:8] = blank ? 7'd0 : fssd_pkg::seg_pattern(cur_digit);
        m_axis_tuser[0] = blank;
        m_axis_tuser[1] = (pos_reg == fssd_pkg::POS_W'(fssd_pkg::DP_POS));
        m_axis_tuser[2] = (pos_reg < fssd_pkg::POS_W'(fssd_pkg::SMALL_DIGITS));
        m_axis_tlast = (pos_reg == last_pos_reg);
    end

    // never taking input while a digit is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while output valid");

    // the last digit taken frees the input side
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after last digit");

    // digit position stays inside the display
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <=
            fssd_pkg::POS_W'(fssd_pkg::FIXED_DIGITS + fssd_pkg::MAX_MHZ_DIGITS - 1)))
        else $error("digit position out of range");

    // blanking only on MHz digits and with all segments dark
    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[14:8] == 7'd0 && m_axis_tdata[3:0] >= fssd_pkg::FIRST_MHZ_POS))
        else $error("bad blanked digit");

    // a run never ends before the MHz units digit
    a_min_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[3:0] >= fssd_pkg::FIRST_MHZ_POS))
        else $error("run ended early");

endmodule
`default_nettype wire
